// ----- sv/ptcp_pkg.sv -----
// ----------------------------------------------------------------------------
// ptcp_pkg: shared constants for the point-triangle closest point block
// Default coordinate width, multiplier slice width and distance format.
// ----------------------------------------------------------------------------
package ptcp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MUL_CHUNK       = 16;
  localparam int DIST_WIDTH      = 33;

  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

endpackage

// ----- sv/ptcp_delay.sv -----
// ----------------------------------------------------------------------------
// ptcp_delay: fixed-length register line
// Carries side data alongside the arithmetic pipeline.
// ----------------------------------------------------------------------------
module ptcp_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_tap
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        line_q[k] <= d_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  assign d_o = line_q[DEPTH-1];

endmodule

// ----- sv/ptcp_mul.sv -----
// ----------------------------------------------------------------------------
// ptcp_mul: pipelined signed multiplier
// Takes one CW-bit slice of b per stage and accumulates the partial products.
// ----------------------------------------------------------------------------
module ptcp_mul #(
  parameter int WA = 33,
  parameter int WB = 33,
  parameter int CW = ptcp_pkg::MUL_CHUNK
) (
  input  logic                    clk_i,
  input  logic signed [WA-1:0]    a_i,
  input  logic signed [WB-1:0]    b_i,
  output logic signed [WA+WB-1:0] p_o
);

  localparam int N  = (WB + CW - 1) / CW;
  localparam int BX = N * CW;
  localparam int PW = WA + WB;

  logic signed [BX-1:0] bx;
  logic signed [WA-1:0] a_q   [N-1];
  logic signed [BX-1:0] b_q   [N-1];
  logic signed [PW-1:0] acc_q [N];

  assign bx = BX'(b_i);

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic signed [WA-1:0] a_s;
    logic signed [BX-1:0] b_s;
    logic signed [PW-1:0] acc_s;
    logic signed [CW:0]   chunk;
    logic signed [WA+CW:0] pp;
    logic signed [PW-1:0] acc_d;

    if (k == 0) begin : g_first
      assign a_s   = a_i;
      assign b_s   = bx;
      assign acc_s = '0;
    end else begin : g_next
      assign a_s   = a_q[k-1];
      assign b_s   = b_q[k-1];
      assign acc_s = acc_q[k-1];
    end

    if (k == N - 1) begin : g_top
      assign chunk = {b_s[BX-1], b_s[k*CW +: CW]};
    end else begin : g_low
      assign chunk = {1'b0, b_s[k*CW +: CW]};
    end

    assign pp    = a_s * chunk;
    assign acc_d = acc_s + (PW'(pp) <<< (k * CW));

    always_ff @(posedge clk_i) begin
      acc_q[k] <= acc_d;
    end

    if (k < N - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        a_q[k] <= a_s;
        b_q[k] <= b_s;
      end
    end
  end

  assign p_o = acc_q[N-1];

endmodule

// ----- sv/ptcp_div.sv -----
// ----------------------------------------------------------------------------
// ptcp_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module ptcp_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 34
) (
  input  logic          clk_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] d_q   [QW-1];
  logic [QW-1:0] q_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [NW-1:0] rem_s;
    logic [DW-1:0] d_s;
    logic [QW-1:0] q_s;
    logic [XW-1:0] trial;
    logic [XW-1:0] rem_x;
    logic          ge;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] q_d;

    if (k == 0) begin : g_first
      assign rem_s = n_i;
      assign d_s   = d_i;
      assign q_s   = '0;
    end else begin : g_next
      assign rem_s = rem_q[k-1];
      assign d_s   = d_q[k-1];
      assign q_s   = q_q[k-1];
    end

    assign trial = XW'(d_s) << B;
    assign rem_x = XW'(rem_s);
    assign ge    = rem_x >= trial;
    assign rem_d = ge ? NW'(rem_x - trial) : rem_s;
    assign q_d   = q_s | (QW'(ge) << B);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      q_q[k]   <= q_d;
    end

    if (k < QW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        d_q[k] <= d_s;
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

// ----- sv/ptcp_sqrt.sv -----
// ----------------------------------------------------------------------------
// ptcp_sqrt: pipelined integer square root
// One root bit per stage, floor of the square root of a 2*RW-bit value.
// ----------------------------------------------------------------------------
module ptcp_sqrt #(
  parameter int RW = 34
) (
  input  logic              clk_i,
  input  logic [2*RW-1:0]   x_i,
  output logic [RW-1:0]     root_o
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] x_q    [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [RW+1:0]   rem_s;
    logic [RW-1:0]   root_s;
    logic [2*RW-1:0] x_s;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_s  = '0;
      assign root_s = '0;
      assign x_s    = x_i;
    end else begin : g_next
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign x_s    = x_q[k-1];
    end

    assign rem_sh = {rem_s[RW-1:0], x_s[2*B +: 2]};
    assign trial  = {root_s, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
      root_q[k] <= {root_s[RW-2:0], ge};
    end

    if (k < RW - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        x_q[k] <= x_s;
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// ----- sv/ptcp_region.sv -----
// ----------------------------------------------------------------------------
// ptcp_region: region classification and parameter clamp
// Picks one of four regions, then clamps the edge parameter to [0,1].
// ----------------------------------------------------------------------------
module ptcp_region #(
  parameter int DOTW = 68,
  parameter int WIDE = 138
) (
  input  logic                   clk_i,
  input  logic signed [DOTW-1:0] a_i,
  input  logic signed [DOTW-1:0] b_i,
  input  logic signed [DOTW-1:0] c_i,
  input  logic signed [DOTW-1:0] d_i,
  input  logic signed [DOTW-1:0] e_i,
  input  logic signed [WIDE-1:0] det_i,
  input  logic signed [WIDE-1:0] s_i,
  input  logic signed [WIDE-1:0] t_i,
  output logic signed [WIDE-1:0] sn_o,
  output logic signed [WIDE-1:0] tn_o,
  output logic signed [WIDE-1:0] den_o,
  output logic                   deg_o
);

  typedef enum logic [1:0] {
    REGION_FACE,
    REGION_S_EDGE,
    REGION_T_EDGE,
    REGION_FAR
  } region_e;

  logic signed [WIDE-1:0] ax, bx, cx, dx, ex;
  logic signed [WIDE-1:0] sumq, tmp1, numer, denom, st, ad, be;
  region_e                region_d, region_q;
  logic signed [WIDE-1:0] num_d, num_q, den_d, den_q, t_q;

  assign ax    = WIDE'(a_i);
  assign bx    = WIDE'(b_i);
  assign cx    = WIDE'(c_i);
  assign dx    = WIDE'(d_i);
  assign ex    = WIDE'(e_i);
  assign sumq  = bx + dx;
  assign tmp1  = cx + ex;
  assign numer = tmp1 - sumq;
  assign denom = ax - (bx <<< 1) + cx;
  assign st    = s_i + t_i;
  assign ad    = ax + dx;
  assign be    = bx + ex;

  always_comb begin
    priority if (st < det_i) begin
      priority if (s_i[WIDE-1]) begin
        region_d = (t_i[WIDE-1] && d_i[DOTW-1]) ? REGION_S_EDGE : REGION_T_EDGE;
      end else if (t_i[WIDE-1]) begin
        region_d = REGION_S_EDGE;
      end else begin
        region_d = REGION_FACE;
      end
    end else if (s_i[WIDE-1]) begin
      region_d = (tmp1 > sumq) ? REGION_FAR : REGION_T_EDGE;
    end else if (t_i[WIDE-1]) begin
      region_d = (ad > be) ? REGION_FAR : REGION_S_EDGE;
    end else begin
      region_d = REGION_FAR;
    end
  end

  always_comb begin
    unique case (region_d)
      REGION_FACE: begin
        num_d = s_i;
        den_d = det_i;
      end
      REGION_S_EDGE: begin
        num_d = -dx;
        den_d = ax;
      end
      REGION_T_EDGE: begin
        num_d = -ex;
        den_d = cx;
      end
      default: begin
        num_d = numer;
        den_d = denom;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    region_q <= region_d;
    num_q    <= num_d;
    den_q    <= den_d;
    t_q      <= t_i;
  end

  logic                   dz;
  logic signed [WIDE-1:0] pn, pd;
  logic signed [WIDE-1:0] sn_d, tn_d, dn_d;
  logic                   dg_d;

  assign dz = (den_q == '0);

  always_comb begin
    priority if (dz) begin
      pn = '0;
      pd = WIDE'(1);
    end else if (num_q <= 0) begin
      pn = '0;
      pd = WIDE'(1);
    end else if (num_q >= den_q) begin
      pn = WIDE'(1);
      pd = WIDE'(1);
    end else begin
      pn = num_q;
      pd = den_q;
    end
  end

  always_comb begin
    unique case (region_q)
      REGION_FACE: begin
        sn_d = num_q;
        tn_d = t_q;
        dn_d = den_q;
        dg_d = 1'b0;
      end
      REGION_S_EDGE: begin
        sn_d = pn;
        tn_d = '0;
        dn_d = pd;
        dg_d = dz;
      end
      REGION_T_EDGE: begin
        sn_d = '0;
        tn_d = pn;
        dn_d = pd;
        dg_d = dz;
      end
      default: begin
        sn_d = pn;
        tn_d = pd - pn;
        dn_d = pd;
        dg_d = dz;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sn_o  <= sn_d;
    tn_o  <= tn_d;
    den_o <= dn_d;
    deg_o <= dg_d;
  end

endmodule

// ----- sv/point_triangle_closest_point.sv -----
// ----------------------------------------------------------------------------
// point_triangle_closest_point: closest point on a triangle and its distance
// Fully pipelined; one query point and three vertices in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at each rising edge with start high; busy stays
//   low, so a new transaction may follow in every cycle.
//   Each result appears on closest_*_o, distance_o and degenerate_o for one
//   cycle with done_o high, in the order the transactions were taken.
//   The pipeline is built from the slice-per-stage multipliers, the
//   bit-per-stage divider for the rounded closest point and the
//   bit-per-stage square root.
//   Throughput is one transaction per cycle.
//   Reset clears the valid line only; transactions in flight are dropped.
//   The receiver cannot hold results off, so nothing ever stalls.
//   degenerate_o flags a zero denominator; distance_o saturates.
// ----------------------------------------------------------------------------
module point_triangle_closest_point #(
  parameter int COORD_WIDTH = ptcp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       point_x_i,
  input  logic signed [COORD_WIDTH-1:0]       point_y_i,
  input  logic signed [COORD_WIDTH-1:0]       point_z_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex0_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex0_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex0_z_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex1_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex1_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex1_z_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex2_x_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex2_y_i,
  input  logic signed [COORD_WIDTH-1:0]       vertex2_z_i,
  output logic                                done_o,
  output logic signed [COORD_WIDTH-1:0]       closest_x_o,
  output logic signed [COORD_WIDTH-1:0]       closest_y_o,
  output logic signed [COORD_WIDTH-1:0]       closest_z_o,
  output logic [ptcp_pkg::DIST_WIDTH-1:0]     distance_o,
  output logic                                degenerate_o
);

  localparam int W    = COORD_WIDTH;
  localparam int EW   = W + 1;
  localparam int CW   = ptcp_pkg::MUL_CHUNK;
  localparam int DOTW = 2 * EW + 2;
  localparam int WIDE = 2 * DOTW + 2;
  localparam int PW3  = EW + WIDE;
  localparam int NW   = PW3 + 3;
  localparam int QW   = W + 2;
  localparam int RW   = W + 2;
  localparam int SQW  = 2 * RW;
  localparam int DSW  = ptcp_pkg::DIST_WIDTH;
  localparam int XW   = (RW > DSW) ? RW : DSW;
  localparam int LM1  = (EW + CW - 1) / CW;
  localparam int LM2  = (DOTW + CW - 1) / CW;
  localparam int LM3  = (WIDE + CW - 1) / CW;
  localparam int DD   = LM1 + 2;
  localparam int DT   = DD + LM2 + 1;
  localparam int DR   = DT + 2;
  localparam int DN   = DR + LM3 + 1;
  localparam int DC   = DN + QW + 1;
  localparam int DS   = DC + LM1 + 1;
  localparam int LAT  = DS + RW + 1;

  logic             accept;
  logic [LAT-1:0]   valid_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LAT-2:0], accept};
    end
  end

  assign done_o = valid_q[LAT-1];

  logic signed [W-1:0]  pin  [3];
  logic signed [W-1:0]  v0in [3];
  logic signed [W-1:0]  v1in [3];
  logic signed [W-1:0]  v2in [3];
  logic signed [W-1:0]  p_q  [3];
  logic signed [W-1:0]  v0_q [3];
  logic signed [EW-1:0] e0_q [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] g_q  [3];

  assign pin[0]  = point_x_i;
  assign pin[1]  = point_y_i;
  assign pin[2]  = point_z_i;
  assign v0in[0] = vertex0_x_i;
  assign v0in[1] = vertex0_y_i;
  assign v0in[2] = vertex0_z_i;
  assign v1in[0] = vertex1_x_i;
  assign v1in[1] = vertex1_y_i;
  assign v1in[2] = vertex1_z_i;
  assign v2in[0] = vertex2_x_i;
  assign v2in[1] = vertex2_y_i;
  assign v2in[2] = vertex2_z_i;

  logic signed [2*EW-1:0] p_aa [3];
  logic signed [2*EW-1:0] p_bb [3];
  logic signed [2*EW-1:0] p_cc [3];
  logic signed [2*EW-1:0] p_dd [3];
  logic signed [2*EW-1:0] p_ee [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis_in
    always_ff @(posedge clk_i) begin
      p_q[k]  <= pin[k];
      v0_q[k] <= v0in[k];
      e0_q[k] <= EW'(v1in[k]) - EW'(v0in[k]);
      e1_q[k] <= EW'(v2in[k]) - EW'(v0in[k]);
      g_q[k]  <= EW'(v0in[k]) - EW'(pin[k]);
    end

    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_a (
      .clk_i(clk_i), .a_i(e0_q[k]), .b_i(e0_q[k]), .p_o(p_aa[k]));
    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_b (
      .clk_i(clk_i), .a_i(e0_q[k]), .b_i(e1_q[k]), .p_o(p_bb[k]));
    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_c (
      .clk_i(clk_i), .a_i(e1_q[k]), .b_i(e1_q[k]), .p_o(p_cc[k]));
    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_d (
      .clk_i(clk_i), .a_i(e0_q[k]), .b_i(g_q[k]), .p_o(p_dd[k]));
    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_e (
      .clk_i(clk_i), .a_i(e1_q[k]), .b_i(g_q[k]), .p_o(p_ee[k]));
  end

  logic signed [DOTW-1:0] a_q, b_q, c_q, d_q, e_q;

  always_ff @(posedge clk_i) begin
    a_q <= DOTW'(p_aa[0]) + DOTW'(p_aa[1]) + DOTW'(p_aa[2]);
    b_q <= DOTW'(p_bb[0]) + DOTW'(p_bb[1]) + DOTW'(p_bb[2]);
    c_q <= DOTW'(p_cc[0]) + DOTW'(p_cc[1]) + DOTW'(p_cc[2]);
    d_q <= DOTW'(p_dd[0]) + DOTW'(p_dd[1]) + DOTW'(p_dd[2]);
    e_q <= DOTW'(p_ee[0]) + DOTW'(p_ee[1]) + DOTW'(p_ee[2]);
  end

  logic signed [2*DOTW-1:0] p_ac, p_b2, p_be, p_cd, p_bd, p_ae;

  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_ac (
    .clk_i(clk_i), .a_i(a_q), .b_i(c_q), .p_o(p_ac));
  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_b2 (
    .clk_i(clk_i), .a_i(b_q), .b_i(b_q), .p_o(p_b2));
  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_be (
    .clk_i(clk_i), .a_i(b_q), .b_i(e_q), .p_o(p_be));
  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_cd (
    .clk_i(clk_i), .a_i(c_q), .b_i(d_q), .p_o(p_cd));
  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_bd (
    .clk_i(clk_i), .a_i(b_q), .b_i(d_q), .p_o(p_bd));
  ptcp_mul #(.WA(DOTW), .WB(DOTW), .CW(CW)) u_mul_ae (
    .clk_i(clk_i), .a_i(a_q), .b_i(e_q), .p_o(p_ae));

  logic signed [WIDE-1:0] det_q, s_q, t_q;

  always_ff @(posedge clk_i) begin
    det_q <= WIDE'(p_ac) - WIDE'(p_b2);
    s_q   <= WIDE'(p_be) - WIDE'(p_cd);
    t_q   <= WIDE'(p_bd) - WIDE'(p_ae);
  end

  logic [5*DOTW-1:0]      dot_pk, dot_dl;
  logic signed [DOTW-1:0] a_r, b_r, c_r, d_r, e_r;

  assign dot_pk = {a_q, b_q, c_q, d_q, e_q};

  ptcp_delay #(.WIDTH(5*DOTW), .DEPTH(LM2+1)) u_dly_dot (
    .clk_i(clk_i), .d_i(dot_pk), .d_o(dot_dl));

  assign a_r = dot_dl[4*DOTW +: DOTW];
  assign b_r = dot_dl[3*DOTW +: DOTW];
  assign c_r = dot_dl[2*DOTW +: DOTW];
  assign d_r = dot_dl[DOTW +: DOTW];
  assign e_r = dot_dl[0 +: DOTW];

  logic signed [WIDE-1:0] sn, tn, den;
  logic                   deg;

  ptcp_region #(.DOTW(DOTW), .WIDE(WIDE)) u_region (
    .clk_i (clk_i),
    .a_i   (a_r),
    .b_i   (b_r),
    .c_i   (c_r),
    .d_i   (d_r),
    .e_i   (e_r),
    .det_i (det_q),
    .s_i   (s_q),
    .t_i   (t_q),
    .sn_o  (sn),
    .tn_o  (tn),
    .den_o (den),
    .deg_o (deg)
  );

  logic [6*EW-1:0]      e_pk, e_dl;
  logic [6*W-1:0]       pv_pk, pv_dl;
  logic [WIDE-1:0]      den_dl;
  logic signed [EW-1:0] e0_r [3];
  logic signed [EW-1:0] e1_r [3];
  logic signed [W-1:0]  p_r  [3];
  logic signed [W-1:0]  v0_r [3];

  ptcp_delay #(.WIDTH(6*EW), .DEPTH(DR-1)) u_dly_edge (
    .clk_i(clk_i), .d_i(e_pk), .d_o(e_dl));
  ptcp_delay #(.WIDTH(6*W), .DEPTH(DN+QW-1)) u_dly_pv (
    .clk_i(clk_i), .d_i(pv_pk), .d_o(pv_dl));
  ptcp_delay #(.WIDTH(WIDE), .DEPTH(LM3)) u_dly_den (
    .clk_i(clk_i), .d_i(den), .d_o(den_dl));

  logic signed [PW3-1:0] p_s [3];
  logic signed [PW3-1:0] p_t [3];
  logic [NW-1:0]         nn_q [3];
  logic [WIDE:0]         dd_q;
  logic [2:0]            neg_q, neg_dl;
  logic [QW-1:0]         quo [3];

  always_ff @(posedge clk_i) begin
    dd_q <= {den_dl, 1'b0};
  end

  ptcp_delay #(.WIDTH(3), .DEPTH(QW)) u_dly_neg (
    .clk_i(clk_i), .d_i(neg_q), .d_o(neg_dl));

  logic signed [W-1:0]  cp_q [3];
  logic signed [EW-1:0] df_q [3];
  logic signed [2*EW-1:0] p_sq [3];
  logic [3*W-1:0]       cp_pk, cp_dl;

  for (genvar k = 0; k < 3; k++) begin : g_axis_out
    logic signed [PW3:0]  sum3;
    logic [PW3:0]         mag;
    logic signed [W+2:0]  qv;
    logic signed [W+2:0]  cpw;
    logic signed [W-1:0]  cp_d;

    assign e_pk[k*EW +: EW]       = e0_q[k];
    assign e_pk[(3+k)*EW +: EW]   = e1_q[k];
    assign e0_r[k]                = e_dl[k*EW +: EW];
    assign e1_r[k]                = e_dl[(3+k)*EW +: EW];
    assign pv_pk[k*W +: W]        = p_q[k];
    assign pv_pk[(3+k)*W +: W]    = v0_q[k];
    assign p_r[k]                 = pv_dl[k*W +: W];
    assign v0_r[k]                = pv_dl[(3+k)*W +: W];

    ptcp_mul #(.WA(EW), .WB(WIDE), .CW(CW)) u_mul_s (
      .clk_i(clk_i), .a_i(e0_r[k]), .b_i(sn), .p_o(p_s[k]));
    ptcp_mul #(.WA(EW), .WB(WIDE), .CW(CW)) u_mul_t (
      .clk_i(clk_i), .a_i(e1_r[k]), .b_i(tn), .p_o(p_t[k]));

    assign sum3 = (PW3+1)'(p_s[k]) + (PW3+1)'(p_t[k]);
    assign mag  = sum3[PW3] ? $unsigned(-sum3) : $unsigned(sum3);

    always_ff @(posedge clk_i) begin
      nn_q[k]  <= NW'({mag, 1'b0}) + NW'($unsigned(den_dl));
      neg_q[k] <= sum3[PW3];
    end

    ptcp_div #(.NW(NW), .DW(WIDE+1), .QW(QW)) u_div (
      .clk_i(clk_i), .n_i(nn_q[k]), .d_i(dd_q), .q_o(quo[k]));

    assign qv   = neg_dl[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
    assign cpw  = (W+3)'(v0_r[k]) + qv;
    assign cp_d = cpw[W-1:0];

    always_ff @(posedge clk_i) begin
      cp_q[k] <= cp_d;
      df_q[k] <= EW'(cp_d) - EW'(p_r[k]);
    end

    ptcp_mul #(.WA(EW), .WB(EW), .CW(CW)) u_mul_sq (
      .clk_i(clk_i), .a_i(df_q[k]), .b_i(df_q[k]), .p_o(p_sq[k]));

    assign cp_pk[k*W +: W] = cp_q[k];
  end

  logic signed [SQW-1:0] sum_q;
  logic [RW-1:0]         root;
  logic [XW-1:0]         root_x;
  logic                  deg_dl;

  always_ff @(posedge clk_i) begin
    sum_q <= SQW'(p_sq[0]) + SQW'(p_sq[1]) + SQW'(p_sq[2]);
  end

  ptcp_sqrt #(.RW(RW)) u_sqrt (
    .clk_i(clk_i), .x_i($unsigned(sum_q)), .root_o(root));

  ptcp_delay #(.WIDTH(3*W), .DEPTH(LM1+1+RW)) u_dly_cp (
    .clk_i(clk_i), .d_i(cp_pk), .d_o(cp_dl));
  ptcp_delay #(.WIDTH(1), .DEPTH(LAT-1-DR)) u_dly_deg (
    .clk_i(clk_i), .d_i(deg), .d_o(deg_dl));

  assign root_x = XW'(root);

  logic signed [W-1:0] out_x_q, out_y_q, out_z_q;
  logic [DSW-1:0]      out_dist_q;
  logic                out_deg_q;

  always_ff @(posedge clk_i) begin
    out_x_q    <= cp_dl[0 +: W];
    out_y_q    <= cp_dl[W +: W];
    out_z_q    <= cp_dl[2*W +: W];
    out_dist_q <= (root_x > XW'(ptcp_pkg::DIST_MAX)) ? ptcp_pkg::DIST_MAX : root_x[DSW-1:0];
    out_deg_q  <= deg_dl;
  end

  assign closest_x_o  = out_x_q;
  assign closest_y_o  = out_y_q;
  assign closest_z_o  = out_z_q;
  assign distance_o   = out_dist_q;
  assign degenerate_o = out_deg_q;

`ifndef ASSERT_OFF
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LAT))
    else $error("result without a transaction LAT cycles earlier");

  a_x_within_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((closest_x_o >= $past(vertex0_x_i, LAT) ||
                 closest_x_o >= $past(vertex1_x_i, LAT) ||
                 closest_x_o >= $past(vertex2_x_i, LAT)) &&
                (closest_x_o <= $past(vertex0_x_i, LAT) ||
                 closest_x_o <= $past(vertex1_x_i, LAT) ||
                 closest_x_o <= $past(vertex2_x_i, LAT))))
    else $error("closest x outside the vertex range");

  a_y_within_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((closest_y_o >= $past(vertex0_y_i, LAT) ||
                 closest_y_o >= $past(vertex1_y_i, LAT) ||
                 closest_y_o >= $past(vertex2_y_i, LAT)) &&
                (closest_y_o <= $past(vertex0_y_i, LAT) ||
                 closest_y_o <= $past(vertex1_y_i, LAT) ||
                 closest_y_o <= $past(vertex2_y_i, LAT))))
    else $error("closest y outside the vertex range");
`endif

endmodule
